// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted keyed table
// Action and status codes, field widths and the slot record layout.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned COUNT_W      = 5;

  typedef logic [1:0] action_t;
  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_LOOKUP = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // One table slot: code, weight in hundredths, one-bit tag
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [WEIGHT_W-1:0] weight;
    logic                tag;
  } slot_t;

endpackage

// ===== rtl/sorted_keyed_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_table_top: bounded table kept sorted by descending weight
// Insert, remove by code and look up by code, one slot per cycle through a
// slot memory with one read and one write port, with a summary of count,
// heaviest and lightest.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid / in_stall | action, key_code, weight, tag
//   output   | out_valid/out_stall | status, found_weight, found_tag,
//            |                     | entry_count, heaviest_*, lightest_*
//
// The sequencer walks the slot memory one slot per cycle (one read, one
// write), then reads the first and last slots for the summary.
// Reset empties the table; slot contents are not cleared, only the count.
// in_stall is high while an item is in work; a stalled result is held in the
// output register while the next item is taken and worked on.
module sorted_keyed_table_top #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  skt_pkg::action_t              action,
  input  logic [skt_pkg::CODE_W-1:0]    key_code,
  input  logic [skt_pkg::WEIGHT_W-1:0]  weight,
  input  logic                          tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output skt_pkg::status_t              status,
  output logic [skt_pkg::WEIGHT_W-1:0]  found_weight,
  output logic                          found_tag,
  output logic [skt_pkg::COUNT_W-1:0]   entry_count,
  output logic [skt_pkg::CODE_W-1:0]    heaviest_code,
  output logic [skt_pkg::WEIGHT_W-1:0]  heaviest_weight,
  output logic                          heaviest_tag,
  output logic [skt_pkg::CODE_W-1:0]    lightest_code,
  output logic [skt_pkg::WEIGHT_W-1:0]  lightest_weight,
  output logic                          lightest_tag
);
  import skt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_PUT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TAIL0,
    S_TAIL1,
    S_TAIL2,
    S_FIN
  } state_t;

  state_t  state;
  idx_t    ptr;
  cnt_t    count;
  logic    found;
  action_t op;
  slot_t   req;
  status_t res_status;
  logic [WEIGHT_W-1:0] res_fw;
  logic    res_ft;
  slot_t   heavy;
  slot_t   light;

  // Slot memory, one write and one registered read per cycle
  slot_t   mem [CAPACITY];
  slot_t   rd_q;
  idx_t    rd_addr;
  logic    wr_en;
  idx_t    wr_addr;
  slot_t   wr_data;

  logic    ins_move;
  logic    hit;
  logic    at_last;

  assign in_stall = (state != S_IDLE);

  assign ins_move = (rd_q.weight <= req.weight);
  assign hit      = (rd_q.code == req.code);
  assign at_last  = (cnt_t'(ptr) == count - 1'b1);

  // Pick read address: prefetch the next slot while the current one is checked
  always_comb begin
    case (state)
      S_INS_CHK:  rd_addr = ptr - 1'b1;
      S_SCAN_CHK: rd_addr = ptr + 1'b1;
      S_TAIL0:    rd_addr = '0;
      S_TAIL1:    rd_addr = idx_t'(count - 1'b1);
      default:    rd_addr = ptr;
    endcase
  end

  // Pick write: move a slot down on insert, up on remove, or place the new one
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = req;
    case (state)
      S_INS_CHK: begin
        wr_en   = 1'b1;
        wr_addr = ptr + 1'b1;
        wr_data = ins_move ? rd_q : req;
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      S_SCAN_CHK: begin
        wr_en   = found && (op == ACT_REMOVE);
        wr_addr = ptr - 1'b1;
        wr_data = rd_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once it transfers, unless a new one loads this cycle
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= action;
            req        <= '{code: key_code, weight: weight, tag: tag};
            found      <= 1'b0;
            res_status <= ST_OK;
            res_fw     <= '0;
            res_ft     <= 1'b0;
            ptr        <= '0;
            case (action)
              ACT_INSERT: begin
                if (count == CAP_CNT) begin
                  res_status <= ST_FULL;
                  state      <= S_TAIL0;
                end else if (count == '0) begin
                  state <= S_INS_PUT;
                end else begin
                  ptr   <= idx_t'(count - 1'b1);
                  state <= S_INS_RD;
                end
              end
              ACT_REMOVE, ACT_LOOKUP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_TAIL0;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              default: begin
                state <= S_TAIL0;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state <= S_INS_CHK;
        end
        // Walk up from the last slot, moving lighter-or-equal entries down
        S_INS_CHK: begin
          if (ins_move) begin
            if (ptr == '0) begin
              state <= S_INS_PUT;
            end else begin
              ptr <= ptr - 1'b1;
            end
          end else begin
            count <= count + 1'b1;
            state <= S_TAIL0;
          end
        end
        S_INS_PUT: begin
          count <= count + 1'b1;
          state <= S_TAIL0;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        // Walk down from slot zero; after a remove match, pull each slot up
        S_SCAN_CHK: begin
          if (!found && hit && (op == ACT_LOOKUP)) begin
            res_fw <= rd_q.weight;
            res_ft <= rd_q.tag;
            state  <= S_TAIL0;
          end else begin
            if (hit) begin
              found <= 1'b1;
            end
            if (at_last) begin
              if (found || hit) begin
                count <= count - 1'b1;
              end else begin
                res_status <= ST_NOTFOUND;
              end
              state <= S_TAIL0;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        S_TAIL0: begin
          state <= S_TAIL1;
        end
        S_TAIL1: begin
          heavy <= rd_q;
          state <= S_TAIL2;
        end
        S_TAIL2: begin
          light <= rd_q;
          state <= S_FIN;
        end
        // Hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            found_weight <= res_fw;
            found_tag    <= res_ft;
            entry_count  <= COUNT_W'(count);
            if (count == '0) begin
              heaviest_code   <= '0;
              heaviest_weight <= '0;
              heaviest_tag    <= 1'b0;
              lightest_code   <= '0;
              lightest_weight <= '0;
              lightest_tag    <= 1'b0;
            end else begin
              heaviest_code   <= heavy.code;
              heaviest_weight <= heavy.weight;
              heaviest_tag    <= heavy.tag;
              lightest_code   <= light.code;
              lightest_weight <= light.weight;
              lightest_tag    <= light.tag;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && in_valid |=> state != S_IDLE)
    else $error("accepted item did not start work");

  a_gap_close_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) && found |-> ptr != '0)
    else $error("gap close would write below slot zero");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(CAPACITY))
    else $error("full status with table not full");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (found_weight == '0) && !found_tag)
    else $error("found fields set on a failed request");

endmodule
